/* sv/pptg_pkg.sv */
// ----------------------------------------------------------------------------
// pptg_pkg
// shared types and constants for the primitive pythagorean triple generator
// ----------------------------------------------------------------------------
`default_nettype none

package pptg_pkg;

  localparam int unsigned GEN_WIDTH = 31;
  localparam int unsigned PROD_WIDTH = 2 * GEN_WIDTH;
  localparam int unsigned RES_WIDTH = 63;

  typedef struct packed {
    logic [GEN_WIDTH-1:0] gen_p;
    logic [GEN_WIDTH-1:0] gen_q;
  } pptg_req_t;

  typedef struct packed {
    logic                 valid_res;
    logic [RES_WIDTH-1:0] odd_leg;
    logic [RES_WIDTH-1:0] even_leg;
    logic [RES_WIDTH-1:0] hypotenuse;
  } pptg_res_t;

  typedef struct packed {
    logic                 start;
    logic [GEN_WIDTH-1:0] op_a;
    logic [GEN_WIDTH-1:0] op_b;
  } gcd_cmd_t;

  typedef struct packed {
    logic busy;
    logic coprime;
  } gcd_stat_t;

endpackage

`default_nettype wire

/* sv/pptg_gcd.sv */
// ----------------------------------------------------------------------------
// pptg_gcd
// iterative binary gcd, one shift or one compare and subtract per cycle,
// reports whether the two operands are coprime
// ----------------------------------------------------------------------------
`default_nettype none

module pptg_gcd (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire pptg_pkg::gcd_cmd_t  cmd_i,
  output pptg_pkg::gcd_stat_t      stat_o
);
  import pptg_pkg::*;

  logic [GEN_WIDTH-1:0] a_q, a_d;
  logic [GEN_WIDTH-1:0] b_q, b_d;
  logic                 busy_q, busy_d;
  logic                 coprime_q, coprime_d;
  logic                 a_gt_b;
  logic [GEN_WIDTH-1:0] diff;

  assign a_gt_b = a_q > b_q;
  assign diff   = a_gt_b ? (a_q - b_q) : (b_q - a_q);

  always_comb begin
    a_d       = a_q;
    b_d       = b_q;
    busy_d    = busy_q;
    coprime_d = coprime_q;
    if (cmd_i.start) begin
      if (!cmd_i.op_a[0] && !cmd_i.op_b[0]) begin
        // common factor of two
        busy_d    = 1'b0;
        coprime_d = 1'b0;
      end else begin
        a_d    = cmd_i.op_a;
        b_d    = cmd_i.op_b;
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_d    = 1'b0;
        coprime_d = (a_q == GEN_WIDTH'(1));
      end else if (!a_q[0]) begin
        a_d = a_q >> 1;
      end else if (!b_q[0]) begin
        b_d = b_q >> 1;
      end else if (a_gt_b) begin
        a_d = diff;
      end else begin
        b_d = diff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      coprime_q <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      coprime_q <= coprime_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  assign stat_o.busy    = busy_q;
  assign stat_o.coprime = coprime_q;

endmodule

`default_nettype wire

/* sv/primitive_pythagorean_triple_gen_unit.sv */
// ----------------------------------------------------------------------------
// primitive_pythagorean_triple_gen_unit
// euclid's formula for a generator pair with a primitive pair check
// ----------------------------------------------------------------------------
// usage:
//   a request (gen_p, gen_q) is taken at a rising edge with start high and
//   busy low. busy stays high until the result is out.
//   the result (valid flag, odd leg, even leg, hypotenuse) is shown on res_o
//   for exactly one cycle, marked by res_valid_o; it must be taken then.
//   busy is already low in that cycle, so a new request may be given there.
// sequence:
//   one 31x31 multiplier is used three times (p*p, q*q, p*q), then one
//   shared adder forms the odd leg and the hypotenuse.
//   the gcd unit runs alongside, one shift or one subtract per cycle;
//   the result comes out once the phases pp, qq, pq, odd and hyp are done
//   and the gcd unit is no longer busy. one request at a time.
// reset:
//   rst_ni clears the sequencer and the strobe; no result is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module primitive_pythagorean_triple_gen_unit (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       start,
  output logic                      busy,
  input  wire pptg_pkg::pptg_req_t  req_i,
  output logic                      res_valid_o,
  output pptg_pkg::pptg_res_t       res_o
);
  import pptg_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  localparam logic [2:0] PH_PP  = 3'd0;
  localparam logic [2:0] PH_QQ  = 3'd1;
  localparam logic [2:0] PH_PQ  = 3'd2;
  localparam logic [2:0] PH_ODD = 3'd3;
  localparam logic [2:0] PH_HYP = 3'd4;

  logic [1:0]            state_q, state_d;
  logic [2:0]            ph_q, ph_d;
  logic                  res_valid_q, res_valid_d;
  logic                  accept;

  logic [GEN_WIDTH-1:0]  p_q, q_q;
  logic                  pair_ok_q;
  logic                  gt_q;
  logic                  both_odd_q;
  logic [RES_WIDTH-1:0]  pp_q, qq_q, pq_q;
  pptg_res_t             res_q;

  logic [GEN_WIDTH-1:0]  mul_a, mul_b;
  logic [PROD_WIDTH-1:0] prod;
  logic                  do_sub;
  logic [RES_WIDTH-1:0]  add_b;
  logic [RES_WIDTH-1:0]  add_sum;

  gcd_cmd_t              gcd_cmd;
  gcd_stat_t             gcd_stat;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign gcd_cmd.start = accept && (req_i.gen_p > req_i.gen_q) && (req_i.gen_q != '0);
  assign gcd_cmd.op_a  = req_i.gen_p;
  assign gcd_cmd.op_b  = req_i.gen_q;

  pptg_gcd u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (gcd_cmd),
    .stat_o (gcd_stat)
  );

  // shared multiplier
  always_comb begin
    case (ph_q)
      PH_PP: begin
        mul_a = p_q;
        mul_b = p_q;
      end
      PH_QQ: begin
        mul_a = q_q;
        mul_b = q_q;
      end
      default: begin
        mul_a = p_q;
        mul_b = q_q;
      end
    endcase
  end

  assign prod = PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);

  // shared adder
  assign do_sub  = (ph_q == PH_ODD);
  assign add_b   = do_sub ? ~qq_q : qq_q;
  assign add_sum = pp_q + add_b + RES_WIDTH'(do_sub);

  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    res_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_MUL;
          ph_d    = PH_PP;
        end
      end
      ST_MUL: begin
        if (ph_q == PH_HYP) begin
          state_d = ST_WAIT;
        end else begin
          ph_d = ph_q + 3'd1;
        end
      end
      ST_WAIT: begin
        if (!gcd_stat.busy) begin
          state_d     = ST_IDLE;
          res_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_PP;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      p_q        <= req_i.gen_p;
      q_q        <= req_i.gen_q;
      gt_q       <= req_i.gen_p > req_i.gen_q;
      pair_ok_q  <= (req_i.gen_p > req_i.gen_q) && (req_i.gen_q != '0);
      both_odd_q <= req_i.gen_p[0] && req_i.gen_q[0];
    end
    if (state_q == ST_MUL) begin
      case (ph_q)
        PH_PP:   pp_q <= RES_WIDTH'(prod);
        PH_QQ:   qq_q <= RES_WIDTH'(prod);
        PH_PQ:   pq_q <= RES_WIDTH'(prod);
        PH_ODD:  res_q.odd_leg <= gt_q ? add_sum : '0;
        PH_HYP: begin
          res_q.hypotenuse <= add_sum;
          res_q.even_leg   <= {pq_q[RES_WIDTH-2:0], 1'b0};
        end
        default: begin
        end
      endcase
    end
    if ((state_q == ST_WAIT) && !gcd_stat.busy) begin
      res_q.valid_res <= pair_ok_q && gcd_stat.coprime && !both_odd_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

/* sv/pptg_checker.sv */
// ----------------------------------------------------------------------------
// pptg_checker
// port level checks on request and result timing of the triple generator
// ----------------------------------------------------------------------------
`default_nettype none

module pptg_checker (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      start,
  input wire                      busy,
  input wire                      res_valid_o,
  input wire pptg_pkg::pptg_res_t res_o
);
  import pptg_pkg::*;

  // a taken request blocks the next one
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after request");

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe longer than one cycle");

  // result only ends a request
  a_strobe_ends_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (!busy && $past(busy)))
    else $error("result strobe outside end of request");

  // a primitive pair always has a nonzero odd leg
  a_valid_odd_leg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.valid_res) |-> (res_o.odd_leg != '0))
    else $error("valid pair with zero odd leg");

  // a taken request is never followed by a result strobe in the next cycle
  a_no_strobe_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !res_valid_o) |=> !res_valid_o)
    else $error("result strobe right after a request");

endmodule

bind primitive_pythagorean_triple_gen_unit pptg_checker u_pptg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

`default_nettype wire
